// ===== src/rtec_pkg.sv =====
// rtec_pkg: constants, types and codes shared by the touch calibration unit
package rtec_pkg;

	// panel and screen geometry
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int CAL_MARGIN    = 16;
	localparam int SAMPLE_BITS   = 12;

	// converter reading and register field width
	localparam int FIELD_W = 12;

	localparam int X_W     = $clog2(SCREEN_WIDTH);
	localparam int Y_W     = $clog2(SCREEN_HEIGHT);
	localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int COORD_W = $clog2(MAX_DIM);

	// Q16 fixed point
	localparam int Q_FRAC  = 16;
	localparam int Q16_ONE = 1 << Q_FRAC;

	// gain divider: dividend magnitude, quotient and step count
	localparam int NUM_W  = Q_FRAC + COORD_W;
	localparam int GAIN_W = NUM_W + 1;
	localparam int CNT_W  = $clog2(NUM_W);

	localparam int NUM_X = (SCREEN_WIDTH - 1 - 2 * CAL_MARGIN) * Q16_ONE;
	localparam int NUM_Y = (SCREEN_HEIGHT - 1 - 2 * CAL_MARGIN) * Q16_ONE;
	localparam int NUM_X_ABS = (NUM_X < 0) ? -NUM_X : NUM_X;
	localparam int NUM_Y_ABS = (NUM_Y < 0) ? -NUM_Y : NUM_Y;
	localparam logic NUM_X_NEG = (NUM_X < 0);
	localparam logic NUM_Y_NEG = (NUM_Y < 0);

	// mapping datapath widths
	localparam int SPAN_W = ((SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W) + 1;
	localparam int PROD_W = GAIN_W + SPAN_W;
	localparam int V_W    = PROD_W - Q_FRAC + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FIELD_W;
	localparam int PRESS_THRESHOLD_RST = 2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_LEFT   = 3'd0,
		REG_CAL_TOP    = 3'd1,
		REG_CAL_RIGHT  = 3'd2,
		REG_CAL_BOTTOM = 3'd3,
		REG_THRESHOLD  = 3'd4,
		REG_FLIP       = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_RELEASED = 2'd2,
		EV_HELD     = 2'd3
	} touch_ev_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] top;
		logic [FIELD_W-1:0] right;
		logic [FIELD_W-1:0] bottom;
	} cal_corners_t;

	typedef struct packed {
		logic                     busy;
		logic signed [GAIN_W-1:0] gain_x;
		logic signed [GAIN_W-1:0] gain_y;
	} gain_status_t;

endpackage

// ===== src/rtec_if.sv =====
// rtec_if: valid/ready channel interfaces for panel polls and results

interface rtec_poll_if import rtec_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] sense_level;
	logic [FIELD_W-1:0] raw_x;
	logic [FIELD_W-1:0] raw_y;
	logic [FIELD_W-1:0] recheck_level;

	modport source (output valid, output sense_level, output raw_x, output raw_y,
		output recheck_level, input ready);
	modport sink (input valid, input sense_level, input raw_x, input raw_y,
		input recheck_level, output ready);
endinterface

interface rtec_result_if import rtec_pkg::*;;
	logic           valid;
	logic           ready;
	logic [1:0]     touch_event;
	logic [X_W-1:0] screen_x;
	logic [Y_W-1:0] screen_y;

	modport source (output valid, output touch_event, output screen_x, output screen_y,
		input ready);
	modport sink (input valid, input touch_event, input screen_x, input screen_y,
		output ready);
endinterface

// ===== src/resistive_touch_event_and_calibration_unit.sv =====
// Top level of the resistive touch event and calibration unit
//
//  channel  dir  handshake            word
//  poll     in   poll.valid/ready     sense_level, raw_x, raw_y, recheck_level
//  result   out  result.valid/ready   touch_event, screen_x, screen_y
//  cfg      in   cfg_we (no stall)    cfg_idx, cfg_data
//
// One poll word per cycle while result.ready keeps up and the gains are settled; each
// result passes the poll register, gain multiply register and result register in turn.
// A write to a calibration corner starts the gain divider, one quotient bit per cycle:
// poll.ready is low after the write until the divider is done, or only while cal_wr_q is
// set for a span of zero. arst_n clears the press flag, held point and all valid flags,
// and sets the gains to unity. Each stage holds its word while the stage behind it is full,
// so a result waiting on result.ready still leaves room for two more polls.
module resistive_touch_event_and_calibration_unit import rtec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rtec_poll_if.sink             poll,
	rtec_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	cal_corners_t       cal_q;
	logic [FIELD_W-1:0] thr_q;
	logic               flip_q;
	logic               cal_wr_q;   // a corner changed last cycle: kick the divider

	gain_status_t gst;

	// panel state
	logic                   was_pressed_q;
	logic [SAMPLE_BITS-1:0] held_x_q, held_y_q;

	// pipeline control
	logic      v_s1, v_s2, out_v_q;
	logic      s1_ld, s2_ld, out_ld;
	logic      poll_acc;
	touch_ev_t ev_s1, ev_s2, ev_q;
	touch_ev_t ev_d;
	logic      touched, confirmed;

	logic [COORD_W-1:0] cx, cy;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= '0;
			thr_q    <= FIELD_W'(PRESS_THRESHOLD_RST);
			flip_q   <= 1'b0;
			cal_wr_q <= 1'b0;
		end else begin
			cal_wr_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_CAL_LEFT: begin
						cal_q.left <= cfg_data[FIELD_W-1:0];
						cal_wr_q   <= 1'b1;
					end
					REG_CAL_TOP: begin
						cal_q.top <= cfg_data[FIELD_W-1:0];
						cal_wr_q  <= 1'b1;
					end
					REG_CAL_RIGHT: begin
						cal_q.right <= cfg_data[FIELD_W-1:0];
						cal_wr_q    <= 1'b1;
					end
					REG_CAL_BOTTOM: begin
						cal_q.bottom <= cfg_data[FIELD_W-1:0];
						cal_wr_q     <= 1'b1;
					end
					REG_THRESHOLD: thr_q  <= cfg_data[FIELD_W-1:0];
					REG_FLIP:      flip_q <= cfg_data[0];
					default: ;  // unmapped index: dropped
				endcase
			end
		end
	end

	rtec_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cal_wr_q),
		.cal    (cal_q),
		.gst    (gst)
	);

	// ---------------------------------------------------------------- handshake
	assign out_ld     = !out_v_q || result.ready;
	assign s2_ld      = !v_s2 || out_ld;
	assign s1_ld      = !v_s1 || s2_ld;
	// gains must be settled before a poll is mapped
	assign poll.ready = s1_ld && !cal_wr_q && !gst.busy;
	assign poll_acc   = poll.valid && poll.ready;

	// ---------------------------------------------------------------- event
	assign touched   = (poll.sense_level > thr_q);
	assign confirmed = touched && (poll.recheck_level > thr_q);

	always_comb begin
		if (touched != was_pressed_q)
			ev_d = touched ? EV_PRESSED : EV_RELEASED;
		else
			ev_d = touched ? EV_HELD : EV_NONE;
	end

	// held point only moves on a confirmed sample; it is also the s1 point,
	// since nothing new is taken while s1 is full and cannot advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			held_x_q      <= '0;
			held_y_q      <= '0;
		end else if (poll_acc) begin
			was_pressed_q <= touched;
			if (confirmed) begin
				held_x_q <= SAMPLE_BITS'(poll.raw_x);
				held_y_q <= SAMPLE_BITS'(poll.raw_y);
			end
		end
	end

	// ---------------------------------------------------------------- pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ld)
				v_s1 <= poll_acc;
			if (s2_ld)
				v_s2 <= v_s1;
			if (out_ld)
				out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_acc)
			ev_s1 <= ev_d;
		if (s2_ld && v_s1)
			ev_s2 <= ev_s1;
		if (out_ld && v_s2) begin
			ev_q <= ev_s2;
			x_q  <= X_W'(cx);
			y_q  <= Y_W'(cy);
		end
	end

	rtec_axis u_axis_x (
		.clk     (clk),
		.ld      (s2_ld && v_s1),
		.held    (held_x_q),
		.origin  (cal_q.left),
		.gain    (gst.gain_x),
		.size_m1 (COORD_W'(SCREEN_WIDTH - 1)),
		.flip    (flip_q),
		.coord   (cx)
	);

	rtec_axis u_axis_y (
		.clk     (clk),
		.ld      (s2_ld && v_s1),
		.held    (held_y_q),
		.origin  (cal_q.top),
		.gain    (gst.gain_y),
		.size_m1 (COORD_W'(SCREEN_HEIGHT - 1)),
		.flip    (flip_q),
		.coord   (cy)
	);

	// ---------------------------------------------------------------- result
	assign result.valid       = out_v_q;
	assign result.touch_event = ev_q;
	assign result.screen_x    = x_q;
	assign result.screen_y    = y_q;

`ifndef SYNTH
	a_no_poll_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(cal_wr_q || gst.busy) |-> !poll.ready)
		else $error("poll taken while gains are being recomputed");

	a_press_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(poll_acc && ev_d == EV_PRESSED) |=> was_pressed_q)
		else $error("press event without press flag");

	a_result_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.screen_x <= X_W'(SCREEN_WIDTH - 1)
			&& result.screen_y <= Y_W'(SCREEN_HEIGHT - 1)))
		else $error("result coordinate off screen");

	a_zero_span_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(!cal_wr_q && !gst.busy && cal_q.left == cal_q.right)
		|-> (gst.gain_x == GAIN_W'(Q16_ONE) && gst.gain_y == GAIN_W'(Q16_ONE)))
		else $error("zero calibration span without unity gains");
`endif

endmodule

// ===== src/rtec_gain.sv =====
// rtec_gain: Q16 gain computation from the calibration corners, one quotient bit per cycle
module rtec_gain import rtec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  cal_corners_t cal,
	output gain_status_t gst
);

	div_state_t state_q, state_d;

	logic signed [FIELD_W:0] dx, dy;
	logic                    zero_span;

	logic [FIELD_W-1:0] den_x_q, den_y_q, rem_x_q, rem_y_q;
	logic [NUM_W-1:0]   quo_x_q, quo_y_q;
	logic               neg_x_q, neg_y_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [GAIN_W-1:0] gain_x_q, gain_y_q;

	logic [FIELD_W+NUM_W-1:0] step_x, step_y;

	function automatic logic [FIELD_W-1:0] abs_span(input logic signed [FIELD_W:0] d);
		logic signed [FIELD_W:0] m;
		m = d[FIELD_W] ? -d : d;
		return m[FIELD_W-1:0];
	endfunction

	// restoring step: returns {remainder, shifted quotient}
	function automatic logic [FIELD_W+NUM_W-1:0] div_step(input logic [FIELD_W-1:0] rem,
		input logic [NUM_W-1:0] quo, input logic [FIELD_W-1:0] den);
		logic [FIELD_W:0] sh;
		logic [FIELD_W:0] diff;
		logic             ge;
		sh   = {rem, quo[NUM_W-1]};
		diff = sh - {1'b0, den};
		ge   = (sh >= {1'b0, den});
		return {(ge ? diff[FIELD_W-1:0] : sh[FIELD_W-1:0]), quo[NUM_W-2:0], ge};
	endfunction

	function automatic logic signed [GAIN_W-1:0] apply_sign(input logic [NUM_W-1:0] quo,
		input logic neg);
		logic signed [GAIN_W-1:0] g;
		g = $signed({1'b0, quo});
		return neg ? -g : g;
	endfunction

	assign dx = $signed({1'b0, cal.right}) - $signed({1'b0, cal.left});
	assign dy = $signed({1'b0, cal.bottom}) - $signed({1'b0, cal.top});
	assign zero_span = (dx == '0) || (dy == '0);

	assign step_x = div_step(rem_x_q, quo_x_q, den_x_q);
	assign step_y = div_step(rem_y_q, quo_y_q, den_y_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start && !zero_span)
					state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (start)
					state_d = zero_span ? DIV_IDLE : DIV_RUN;
				else if (cnt_q == '0)
					state_d = DIV_IDLE;
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		gst.busy   = (state_q == DIV_RUN);
		gst.gain_x = gain_x_q;
		gst.gain_y = gain_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= DIV_IDLE;
			cnt_q    <= '0;
			gain_x_q <= GAIN_W'(Q16_ONE);
			gain_y_q <= GAIN_W'(Q16_ONE);
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W - 1);
				if (zero_span) begin
					gain_x_q <= GAIN_W'(Q16_ONE);
					gain_y_q <= GAIN_W'(Q16_ONE);
				end
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					gain_x_q <= apply_sign(step_x[NUM_W-1:0], neg_x_q);
					gain_y_q <= apply_sign(step_y[NUM_W-1:0], neg_y_q);
				end
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			den_x_q <= abs_span(dx);
			den_y_q <= abs_span(dy);
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= NUM_W'(NUM_X_ABS);
			quo_y_q <= NUM_W'(NUM_Y_ABS);
			neg_x_q <= dx[FIELD_W] ^ NUM_X_NEG;
			neg_y_q <= dy[FIELD_W] ^ NUM_Y_NEG;
		end else if (state_q == DIV_RUN) begin
			{rem_x_q, quo_x_q} <= step_x;
			{rem_y_q, quo_y_q} <= step_y;
		end
	end

endmodule

// ===== src/rtec_axis.sv =====
// rtec_axis: one axis of the point mapping: gain multiply, offset, clamp and mirror
module rtec_axis import rtec_pkg::*; (
	input  logic                     clk,
	input  logic                     ld,
	input  logic [SAMPLE_BITS-1:0]   held,
	input  logic [FIELD_W-1:0]       origin,
	input  logic signed [GAIN_W-1:0] gain,
	input  logic [COORD_W-1:0]       size_m1,
	input  logic                     flip,
	output logic [COORD_W-1:0]       coord
);

	logic signed [SPAN_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_s2;
	logic [PROD_W-Q_FRAC-1:0] fl;
	logic signed [V_W-1:0]    v;
	logic signed [V_W-1:0]    lim;
	logic [COORD_W-1:0]       c;

	assign diff = $signed(SPAN_W'(held)) - $signed(SPAN_W'(origin));

	always_ff @(posedge clk) begin
		if (ld)
			prod_s2 <= gain * diff;
	end

	// arithmetic drop of the fraction is a floor
	always_comb begin
		fl  = prod_s2[PROD_W-1:Q_FRAC];
		v   = $signed({fl[PROD_W-Q_FRAC-1], fl}) + $signed(V_W'(CAL_MARGIN));
		lim = $signed({{(V_W-COORD_W){1'b0}}, size_m1});
		if (v[V_W-1])
			c = '0;
		else if (v > lim)
			c = size_m1;
		else
			c = v[COORD_W-1:0];
		coord = flip ? (size_m1 - c) : c;
	end

endmodule
